### hw/rtl/vrst_pkg.sv
// ----------------------------------------------------------------------------
// vrst_pkg
// Shared types, widths and register codes for the vertex rotate, scale and
// translate pipeline.
// ----------------------------------------------------------------------------
package vrst_pkg;

   localparam int QUAT_W      = 16;
   localparam int POS_W       = 24;
   localparam int RGB_W       = 24;
   localparam int OUT_W       = 32;
   localparam int SCALE_W     = 16;
   localparam int OFFSET_W    = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // q * v products and their three-term sums
   localparam int PROD1_W     = QUAT_W + POS_W;
   localparam int T_W         = PROD1_W + 2;
   // t * q products and their four-term sums
   localparam int PROD2_W     = T_W + QUAT_W;
   localparam int R_W         = PROD2_W + 2;
   localparam int ROT_SHIFT   = 28;
   localparam int ROT_W       = R_W - ROT_SHIFT;
   // rotated value times unsigned scale
   localparam int SC_PROD_W   = ROT_W + SCALE_W + 1;
   localparam int SCALE_SHIFT = 8;
   localparam int SUM_W       = SC_PROD_W + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_QUAT_W       = 3'd0,
      REG_QUAT_X       = 3'd1,
      REG_QUAT_Y       = 3'd2,
      REG_QUAT_Z       = 3'd3,
      REG_SCALE_FACTOR = 3'd4,
      REG_OFFSET_X     = 3'd5,
      REG_OFFSET_Y     = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic signed [QUAT_W-1:0] w;
      logic signed [QUAT_W-1:0] x;
      logic signed [QUAT_W-1:0] y;
      logic signed [QUAT_W-1:0] z;
   } quat_type;

   localparam logic [QUAT_W-1:0]   QUAT_W_RESET   = 16'd16384;
   localparam logic [QUAT_W-1:0]   QUAT_V_RESET   = 16'd0;
   localparam logic [SCALE_W-1:0]  SCALE_RESET    = 16'd5120;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET   = 16'd0;

endpackage

### hw/rtl/vrst_rotate.sv
// ----------------------------------------------------------------------------
// vrst_rotate
// Four-stage quaternion rotation q * (0, v) * conj(q), rounded to Q.8.
// ----------------------------------------------------------------------------
module vrst_rotate (
   input  logic                                 clock,
   input  logic                                 reset,
   input  vrst_pkg::quat_type                   quat,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [vrst_pkg::POS_W-1:0]    pos_x,
   input  logic signed [vrst_pkg::POS_W-1:0]    pos_y,
   input  logic signed [vrst_pkg::POS_W-1:0]    pos_z,
   input  logic        [vrst_pkg::RGB_W-1:0]    rgb_in,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [vrst_pkg::ROT_W-1:0]    rot_x,
   output logic signed [vrst_pkg::ROT_W-1:0]    rot_y,
   output logic signed [vrst_pkg::ROT_W-1:0]    rot_z,
   output logic        [vrst_pkg::RGB_W-1:0]    rgb_out
);

   localparam int NPROD = 12;
   localparam logic signed [vrst_pkg::R_W-1:0] ROT_HALF =
      {{(vrst_pkg::R_W - vrst_pkg::ROT_SHIFT){1'b0}}, 1'b1,
       {(vrst_pkg::ROT_SHIFT - 1){1'b0}}};

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   logic signed [vrst_pkg::PROD1_W-1:0] m1_in [NPROD];
   logic signed [vrst_pkg::PROD1_W-1:0] m1_ff [NPROD];
   logic signed [vrst_pkg::T_W-1:0]     tw_in, tx_in, ty_in, tz_in;
   logic signed [vrst_pkg::T_W-1:0]     tw_ff, tx_ff, ty_ff, tz_ff;
   logic signed [vrst_pkg::PROD2_W-1:0] m2_in [NPROD];
   logic signed [vrst_pkg::PROD2_W-1:0] m2_ff [NPROD];
   logic signed [vrst_pkg::R_W-1:0]     rx_sum, ry_sum, rz_sum;
   logic signed [vrst_pkg::ROT_W-1:0]   rx_ff, ry_ff, rz_ff;
   logic [vrst_pkg::RGB_W-1:0]          rgb1_ff, rgb2_ff, rgb3_ff, rgb4_ff;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // stage 1: q * v products
   always_comb begin
      m1_in[0]  = quat.x * pos_x;
      m1_in[1]  = quat.y * pos_y;
      m1_in[2]  = quat.z * pos_z;
      m1_in[3]  = quat.w * pos_x;
      m1_in[4]  = quat.y * pos_z;
      m1_in[5]  = quat.z * pos_y;
      m1_in[6]  = quat.w * pos_y;
      m1_in[7]  = quat.x * pos_z;
      m1_in[8]  = quat.z * pos_x;
      m1_in[9]  = quat.w * pos_z;
      m1_in[10] = quat.x * pos_y;
      m1_in[11] = quat.y * pos_x;
   end

   // stage 2: t = q * (0, v)
   always_comb begin
      tw_in = -m1_ff[0] - m1_ff[1] - m1_ff[2];
      tx_in =  m1_ff[3] + m1_ff[4] - m1_ff[5];
      ty_in =  m1_ff[6] - m1_ff[7] + m1_ff[8];
      tz_in =  m1_ff[9] + m1_ff[10] - m1_ff[11];
   end

   // stage 3: t * conj(q) products
   always_comb begin
      m2_in[0]  = tw_ff * quat.x;
      m2_in[1]  = tx_ff * quat.w;
      m2_in[2]  = ty_ff * quat.z;
      m2_in[3]  = tz_ff * quat.y;
      m2_in[4]  = tw_ff * quat.y;
      m2_in[5]  = tx_ff * quat.z;
      m2_in[6]  = ty_ff * quat.w;
      m2_in[7]  = tz_ff * quat.x;
      m2_in[8]  = tw_ff * quat.z;
      m2_in[9]  = tx_ff * quat.y;
      m2_in[10] = ty_ff * quat.x;
      m2_in[11] = tz_ff * quat.w;
   end

   // stage 4: vector part, round half up and drop 28 fraction bits
   always_comb begin
      rx_sum = -m2_ff[0] + m2_ff[1] - m2_ff[2]  + m2_ff[3]  + ROT_HALF;
      ry_sum = -m2_ff[4] + m2_ff[5] + m2_ff[6]  - m2_ff[7]  + ROT_HALF;
      rz_sum = -m2_ff[8] - m2_ff[9] + m2_ff[10] + m2_ff[11] + ROT_HALF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         m1_ff   <= m1_in;
         rgb1_ff <= rgb_in;
      end
      if (s2_ready && s1_valid_ff) begin
         tw_ff   <= tw_in;
         tx_ff   <= tx_in;
         ty_ff   <= ty_in;
         tz_ff   <= tz_in;
         rgb2_ff <= rgb1_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         m2_ff   <= m2_in;
         rgb3_ff <= rgb2_ff;
      end
      if (s4_ready && s3_valid_ff) begin
         rx_ff   <= rx_sum[vrst_pkg::R_W-1:vrst_pkg::ROT_SHIFT];
         ry_ff   <= ry_sum[vrst_pkg::R_W-1:vrst_pkg::ROT_SHIFT];
         rz_ff   <= rz_sum[vrst_pkg::R_W-1:vrst_pkg::ROT_SHIFT];
         rgb4_ff <= rgb3_ff;
      end
   end

   assign out_valid = s4_valid_ff;
   assign rot_x     = rx_ff;
   assign rot_y     = ry_ff;
   assign rot_z     = rz_ff;
   assign rgb_out   = rgb4_ff;

endmodule

### hw/rtl/vertex_rotate_scale_translate.sv
// ----------------------------------------------------------------------------
// vertex_rotate_scale_translate
// A vertex reaches the rsp_ port through six register stages, the first loaded
// at the input transfer. Throughput: one vertex per cycle while rsp_stall is
// low; 24 16x24 and 16x42 multipliers over four rotation stages, then three
// 32x17 scale multiplies and a saturating add.
// Reset: clears all stage valid bits and loads the register defaults
// (identity quaternion, scale 20.0, zero offsets).
// ----------------------------------------------------------------------------
module vertex_rotate_scale_translate (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [vrst_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [vrst_pkg::CSR_DATA_W-1:0]       csr_data,
   // input vertex
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [vrst_pkg::POS_W-1:0]     req_pos_x,
   input  logic signed [vrst_pkg::POS_W-1:0]     req_pos_y,
   input  logic signed [vrst_pkg::POS_W-1:0]     req_pos_z,
   input  logic        [vrst_pkg::RGB_W-1:0]     req_rgb_in,
   // result vertex
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [vrst_pkg::OUT_W-1:0]     rsp_screen_x,
   output logic signed [vrst_pkg::OUT_W-1:0]     rsp_screen_y,
   output logic signed [vrst_pkg::OUT_W-1:0]     rsp_depth_z,
   output logic        [vrst_pkg::RGB_W-1:0]     rsp_rgb_out
);

   localparam int SAT_W = vrst_pkg::SUM_W - vrst_pkg::SCALE_SHIFT;
   localparam logic signed [vrst_pkg::SUM_W-1:0] SCALE_HALF =
      {{(vrst_pkg::SUM_W - vrst_pkg::SCALE_SHIFT){1'b0}}, 1'b1,
       {(vrst_pkg::SCALE_SHIFT - 1){1'b0}}};

   vrst_pkg::quat_type                   quat_ff;
   logic [vrst_pkg::SCALE_W-1:0]         scale_ff;
   logic signed [vrst_pkg::OFFSET_W-1:0] offset_x_ff, offset_y_ff;

   logic                                 rot_valid, rot_ready, in_ready;
   logic signed [vrst_pkg::ROT_W-1:0]    rot_x, rot_y, rot_z;
   logic [vrst_pkg::RGB_W-1:0]           rot_rgb;

   logic                                 s5_valid_ff, out_ready;
   logic signed [vrst_pkg::SC_PROD_W-1:0] sx_in, sy_in, sz_in;
   logic signed [vrst_pkg::SC_PROD_W-1:0] sx_ff, sy_ff, sz_ff;
   logic [vrst_pkg::RGB_W-1:0]           rgb5_ff;
   logic signed [vrst_pkg::SCALE_W:0]    scale_s;
   logic signed [vrst_pkg::SUM_W-1:0]    ox_term, oy_term;
   logic signed [vrst_pkg::SUM_W-1:0]    x_sum, y_sum, z_sum;

   logic                                 rsp_valid_ff;
   logic signed [vrst_pkg::OUT_W-1:0]    screen_x_ff, screen_y_ff, depth_z_ff;
   logic [vrst_pkg::RGB_W-1:0]           rgb_out_ff;

   function automatic logic signed [vrst_pkg::OUT_W-1:0] sat_out(
      input logic signed [SAT_W-1:0] v
   );
      logic signed [vrst_pkg::OUT_W-1:0] r;
      if (v > SAT_W'(signed'({1'b0, {(vrst_pkg::OUT_W-1){1'b1}}}))) begin
         r = {1'b0, {(vrst_pkg::OUT_W-1){1'b1}}};
      end else if (v < -SAT_W'(signed'({1'b0, {(vrst_pkg::OUT_W-1){1'b1}}})) - 1) begin
         r = {1'b1, {(vrst_pkg::OUT_W-1){1'b0}}};
      end else begin
         r = v[vrst_pkg::OUT_W-1:0];
      end
      return r;
   endfunction

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff.w   <= vrst_pkg::QUAT_W_RESET;
         quat_ff.x   <= vrst_pkg::QUAT_V_RESET;
         quat_ff.y   <= vrst_pkg::QUAT_V_RESET;
         quat_ff.z   <= vrst_pkg::QUAT_V_RESET;
         scale_ff    <= vrst_pkg::SCALE_RESET;
         offset_x_ff <= vrst_pkg::OFFSET_RESET;
         offset_y_ff <= vrst_pkg::OFFSET_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            vrst_pkg::REG_QUAT_W:       quat_ff.w   <= csr_data;
            vrst_pkg::REG_QUAT_X:       quat_ff.x   <= csr_data;
            vrst_pkg::REG_QUAT_Y:       quat_ff.y   <= csr_data;
            vrst_pkg::REG_QUAT_Z:       quat_ff.z   <= csr_data;
            vrst_pkg::REG_SCALE_FACTOR: scale_ff    <= csr_data;
            vrst_pkg::REG_OFFSET_X:     offset_x_ff <= csr_data;
            vrst_pkg::REG_OFFSET_Y:     offset_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   vrst_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .quat      (quat_ff),
      .in_valid  (req_valid),
      .in_ready  (in_ready),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .pos_z     (req_pos_z),
      .rgb_in    (req_rgb_in),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .rot_x     (rot_x),
      .rot_y     (rot_y),
      .rot_z     (rot_z),
      .rgb_out   (rot_rgb)
   );

   assign req_stall = !in_ready;
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign rot_ready = !s5_valid_ff || out_ready;

   // stage 5: scale
   always_comb begin
      scale_s = signed'({1'b0, scale_ff});
      sx_in   = rot_x * scale_s;
      sy_in   = rot_y * scale_s;
      sz_in   = rot_z * scale_s;
   end

   // stage 6: round, add the x and y offsets in the same sum, saturate
   always_comb begin
      ox_term = {{(vrst_pkg::SUM_W - vrst_pkg::OFFSET_W - 16){offset_x_ff[vrst_pkg::OFFSET_W-1]}},
                 offset_x_ff, 16'd0};
      oy_term = {{(vrst_pkg::SUM_W - vrst_pkg::OFFSET_W - 16){offset_y_ff[vrst_pkg::OFFSET_W-1]}},
                 offset_y_ff, 16'd0};
      x_sum   = vrst_pkg::SUM_W'(sx_ff) + SCALE_HALF + ox_term;
      y_sum   = vrst_pkg::SUM_W'(sy_ff) + SCALE_HALF + oy_term;
      z_sum   = vrst_pkg::SUM_W'(sz_ff) + SCALE_HALF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rot_ready) s5_valid_ff <= rot_valid;
         if (out_ready) rsp_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rot_ready && rot_valid) begin
         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
         sz_ff   <= sz_in;
         rgb5_ff <= rot_rgb;
      end
      if (out_ready && s5_valid_ff) begin
         screen_x_ff <= sat_out(x_sum[vrst_pkg::SUM_W-1:vrst_pkg::SCALE_SHIFT]);
         screen_y_ff <= sat_out(y_sum[vrst_pkg::SUM_W-1:vrst_pkg::SCALE_SHIFT]);
         depth_z_ff  <= sat_out(z_sum[vrst_pkg::SUM_W-1:vrst_pkg::SCALE_SHIFT]);
         rgb_out_ff  <= rgb5_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_screen_x = screen_x_ff;
   assign rsp_screen_y = screen_y_ff;
   assign rsp_depth_z  = depth_z_ff;
   assign rsp_rgb_out  = rgb_out_ff;

endmodule
